### design/zri_pkg.sv
package zri_pkg;

  // Default geometry of the LED line and the row delay
  localparam int LINE_BYTES = 40;
  localparam int ROW_OFFSET = 3;

  // Field widths
  localparam int BYTE_W = 8;
  localparam int CFG_W  = 6;

  // Register reset value
  localparam logic [CFG_W-1:0] WIDTH_RESET = 6'd40;

  // Bit masks for the zigzag mounting
  localparam logic [BYTE_W-1:0] EVEN_MASK = 8'h55;
  localparam logic [BYTE_W-1:0] ODD_MASK  = 8'haa;

  // Input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

endpackage

### design/zri_ram.sv
// Generic single-write, single-read RAM with registered read data
module zri_ram #(
  parameter int WIDTH = zri_pkg::BYTE_W,
  parameter int DEPTH = zri_pkg::LINE_BYTES * zri_pkg::ROW_OFFSET,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/zigzag_row_interleaver.sv
// Zigzag row interleaver for a one-bit LED bar.
// Input stream (s_*): one item per image byte (s_tuser = 0, s_tdata = eight
// packed pixels) or per flush (s_tuser = 1, s_tdata ignored). Rows arrive
// bottom row first. Output stream (m_*): bytes of LINE_BYTES-long LED lines,
// right-aligned with leading zero padding, m_tlast on the final byte.
// Each image byte gives one output byte: its even bits merged with the odd
// bits of the same position ROW_OFFSET rows back. The first byte of a row is
// preceded by LINE_BYTES - width padding bytes. ROW_OFFSET flush items emit
// the trailing odd-bit lines and leave the line store empty.
// Timing: an accepted image byte is read from the line store, merged on the way
// out and registered in the output register, after any padding bytes. A flush
// emits its padding, then streams its stored bytes at one per cycle while the
// receiver accepts them. The block takes one item at a time; it accepts no new
// item until the last byte of the current one has been emitted.
// Reset (rst, synchronous) clears the valid bits of the line store, so it
// reads as all zero at once; no clearing pass is needed. width_bytes returns
// to 40. A stalled receiver holds the output register and stops the sequencer
// in its pad and data states; the line store read data is held meanwhile.
// cfg_we/cfg_wdata write width_bytes; write only while idle.
module zigzag_row_interleaver #(
  parameter int LINE_BYTES = zri_pkg::LINE_BYTES,
  parameter int ROW_OFFSET = zri_pkg::ROW_OFFSET
) (
  input  logic                      clk,
  input  logic                      rst,
  // configuration
  input  logic                      cfg_we,
  input  logic [zri_pkg::CFG_W-1:0] cfg_wdata,   // width_bytes
  // input stream
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [zri_pkg::BYTE_W-1:0] s_tdata,   // [7:0] pixel_bits
  input  logic                       s_tuser,   // [0] kind
  // output stream
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [zri_pkg::BYTE_W-1:0] m_tdata,   // [7:0] line_byte
  output logic                       m_tlast    // last_of_line
);

  localparam int BW     = zri_pkg::BYTE_W;
  localparam int CW     = zri_pkg::CFG_W;
  localparam int DEPTH  = ROW_OFFSET * LINE_BYTES;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int CNT_W  = $clog2(LINE_BYTES + 1);
  localparam int SLOT_W = (ROW_OFFSET > 1) ? $clog2(ROW_OFFSET) : 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PAD  = 2'd1;
  localparam logic [1:0] S_DATA = 2'd2;

  // Registers
  logic [1:0]        state, state_next;
  logic [CW-1:0]     width_bytes;
  logic [SLOT_W-1:0] slot, slot_next;
  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic              kind_q;
  logic [BW-1:0]     pix_q;
  logic [IDX_W-1:0]  cur_i, cur_i_next;
  logic [CNT_W-1:0]  w_q;
  logic [CNT_W-1:0]  pad_cnt, pad_cnt_next;
  logic              rv_q;
  logic [ROW_OFFSET-1:0][LINE_BYTES-1:0] valid;

  // Combinational
  logic [CW:0]       w_clip;
  logic [CNT_W-1:0]  w_use;
  logic [IDX_W-1:0]  i_sel;
  logic [CNT_W-1:0]  pad_len;
  logic              accept;
  logic              out_free;
  logic              emit;
  logic [BW-1:0]     emit_byte;
  logic              emit_last;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_idx;
  logic              wr_en;
  logic              clear_row;
  logic [BW-1:0]     rdata;
  logic [BW-1:0]     stored;
  logic              at_last;

  function automatic logic [ADDR_W-1:0] row_addr(input logic [SLOT_W-1:0] s,
                                                 input logic [IDX_W-1:0] idx);
    row_addr = ADDR_W'(s) * ADDR_W'(LINE_BYTES) + ADDR_W'(idx);
  endfunction

  // Width in use: zero counts as one, clipped to the line length
  always_comb begin
    if (width_bytes == '0) begin
      w_clip = (CW+1)'(1);
    end else if ({1'b0, width_bytes} > (CW+1)'(LINE_BYTES)) begin
      w_clip = (CW+1)'(LINE_BYTES);
    end else begin
      w_clip = {1'b0, width_bytes};
    end
    w_use   = CNT_W'(w_clip);
    pad_len = CNT_W'(LINE_BYTES) - w_use;
    if (CNT_W'(byte_index) >= w_use) begin
      i_sel = IDX_W'(w_use - CNT_W'(1));
    end else begin
      i_sel = byte_index;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign stored   = rv_q ? rdata : '0;
  assign at_last  = (CNT_W'(cur_i) + CNT_W'(1)) == w_q;

  // Sequencer
  always_comb begin
    state_next      = state;
    slot_next       = slot;
    byte_index_next = byte_index;
    cur_i_next      = cur_i;
    pad_cnt_next    = pad_cnt;
    emit            = 1'b0;
    emit_byte       = '0;
    emit_last       = 1'b0;
    rd_en           = 1'b0;
    rd_idx          = i_sel;
    wr_en           = 1'b0;
    clear_row       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          rd_en        = 1'b1;
          rd_idx       = (s_tuser == zri_pkg::KIND_FLUSH) ? '0 : i_sel;
          cur_i_next   = rd_idx;
          pad_cnt_next = pad_len;
          if ((s_tuser == zri_pkg::KIND_FLUSH || byte_index == '0) &&
              pad_len != '0) begin
            state_next = S_PAD;
          end else begin
            state_next = S_DATA;
          end
        end
      end
      S_PAD: begin
        if (out_free) begin
          emit         = 1'b1;
          pad_cnt_next = pad_cnt - CNT_W'(1);
          if (pad_cnt == CNT_W'(1)) begin
            state_next = S_DATA;
          end
        end
      end
      S_DATA: begin
        emit_last = at_last;
        if (kind_q == zri_pkg::KIND_PIXEL) begin
          emit_byte = (pix_q & zri_pkg::EVEN_MASK) | (stored & zri_pkg::ODD_MASK);
        end else begin
          emit_byte = stored & zri_pkg::ODD_MASK;
        end
        if (out_free) begin
          emit = 1'b1;
          if (kind_q == zri_pkg::KIND_PIXEL) begin
            wr_en      = 1'b1;
            state_next = S_IDLE;
            if (at_last) begin
              slot_next       = (slot == SLOT_W'(ROW_OFFSET - 1)) ? '0 : slot + SLOT_W'(1);
              byte_index_next = '0;
            end else begin
              byte_index_next = cur_i + IDX_W'(1);
            end
          end else if (at_last) begin
            clear_row       = 1'b1;
            slot_next       = (slot == SLOT_W'(ROW_OFFSET - 1)) ? '0 : slot + SLOT_W'(1);
            byte_index_next = '0;
            state_next      = S_IDLE;
          end else begin
            // stream the next stored byte of the flushed row
            rd_en      = 1'b1;
            rd_idx     = cur_i + IDX_W'(1);
            cur_i_next = rd_idx;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot        <= '0;
      byte_index  <= '0;
      width_bytes <= zri_pkg::WIDTH_RESET;
      m_tvalid    <= 1'b0;
      valid       <= '0;
    end else begin
      state      <= state_next;
      slot       <= slot_next;
      byte_index <= byte_index_next;
      if (cfg_we) begin
        width_bytes <= cfg_wdata;
      end
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (wr_en) begin
        valid[slot][cur_i] <= 1'b1;
      end
      if (clear_row) begin
        valid[slot] <= '0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_i   <= cur_i_next;
    pad_cnt <= pad_cnt_next;
    if (accept) begin
      kind_q <= s_tuser;
      pix_q  <= s_tdata;
      w_q    <= w_use;
    end
    if (rd_en) begin
      rv_q <= valid[slot][rd_idx];
    end
    if (emit) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_last;
    end
  end

  // Line store: ROW_OFFSET rows of LINE_BYTES bytes
  zri_ram #(
    .WIDTH(BW),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr(row_addr(slot, cur_i)),
    .wdata(pix_q),
    .re   (rd_en),
    .raddr(row_addr(slot, rd_idx)),
    .rdata(rdata)
  );

`ifndef SYNTHESIS
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    slot <= SLOT_W'(ROW_OFFSET - 1))
    else $error("ring slot out of range");

  a_index_range: assert property (@(posedge clk) disable iff (rst)
    CNT_W'(byte_index) < CNT_W'(LINE_BYTES))
    else $error("byte index out of range");

  a_data_in_line: assert property (@(posedge clk) disable iff (rst)
    state == S_DATA |-> CNT_W'(cur_i) < w_q)
    else $error("data position beyond line width");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("item accepted while previous item in progress");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    state == S_PAD && emit |=> m_tdata == '0 && !m_tlast)
    else $error("padding byte not zero");
`endif

endmodule

### bench/zigzag_row_interleaver_check.sv
module zigzag_row_interleaver_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [zri_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [zri_pkg::BYTE_W-1:0] s_tdata,
  input  logic                       s_tuser,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [zri_pkg::BYTE_W-1:0] m_tdata,
  input  logic                       m_tlast,
  output int                         pending,
  output int                         fail_count
);

  typedef struct packed {
    logic [zri_pkg::BYTE_W-1:0] line_byte;
    logic                       last_of_line;
  } led_byte_t;

  // Shadow of the block: three-row line store, ring position, column
  logic [zri_pkg::BYTE_W-1:0] row_mem [zri_pkg::ROW_OFFSET][zri_pkg::LINE_BYTES];
  int                         ring_pos;
  int                         col_pos;
  logic [zri_pkg::CFG_W-1:0]  width_reg;
  led_byte_t                  led_bytes_due[$];
  int                         mismatches;

  function automatic int clipped_width();
    if (width_reg == 0) return 1;
    if (width_reg > zri_pkg::LINE_BYTES) return zri_pkg::LINE_BYTES;
    return int'(width_reg);
  endfunction

  function automatic void next_row();
    ring_pos = (ring_pos + 1) % zri_pkg::ROW_OFFSET;
    col_pos = 0;
  endfunction

  // Expected LED bytes for one accepted item
  function automatic void interleave_item(input logic flush,
                                          input logic [zri_pkg::BYTE_W-1:0] pix);
    int w;
    int i;
    led_byte_t b;
    w = clipped_width();
    if (flush || col_pos == 0) begin
      for (int k = 0; k < zri_pkg::LINE_BYTES - w; k++) begin
        b.line_byte = '0;
        b.last_of_line = 1'b0;
        led_bytes_due.push_back(b);
      end
    end
    if (flush) begin
      for (int k = 0; k < w; k++) begin
        b.line_byte = row_mem[ring_pos][k] & zri_pkg::ODD_MASK;
        b.last_of_line = (k + 1 == w);
        led_bytes_due.push_back(b);
      end
      for (int k = 0; k < zri_pkg::LINE_BYTES; k++) row_mem[ring_pos][k] = '0;
      next_row();
    end else begin
      i = (col_pos >= w) ? w - 1 : col_pos;
      b.line_byte = (pix & zri_pkg::EVEN_MASK) | (row_mem[ring_pos][i] & zri_pkg::ODD_MASK);
      b.last_of_line = (i + 1 >= w);
      led_bytes_due.push_back(b);
      row_mem[ring_pos][i] = pix;
      if (b.last_of_line) next_row();
      else col_pos = i + 1;
    end
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endfunction

  always @(posedge clk) begin
    led_byte_t want;
    if (rst) begin
      for (int r = 0; r < zri_pkg::ROW_OFFSET; r++)
        for (int k = 0; k < zri_pkg::LINE_BYTES; k++) row_mem[r][k] = '0;
      ring_pos = 0;
      col_pos = 0;
      width_reg = zri_pkg::WIDTH_RESET;
      led_bytes_due.delete();
    end else begin
      // Output side first: a result never belongs to an item taken this edge
      if (m_tvalid && m_tready) begin
        if (led_bytes_due.size() == 0) begin
          note_mismatch("unexpected item, line_byte", 0, m_tdata);
        end else begin
          want = led_bytes_due.pop_front();
          if (m_tdata !== want.line_byte)
            note_mismatch("line_byte", want.line_byte, m_tdata);
          if (m_tlast !== want.last_of_line)
            note_mismatch("last_of_line", want.last_of_line, m_tlast);
        end
      end
      if (cfg_we) width_reg = cfg_wdata;
      if (s_tvalid && s_tready)
        interleave_item(s_tuser == zri_pkg::KIND_FLUSH, s_tdata);
    end
    pending <= led_bytes_due.size();
    fail_count <= mismatches;
  end

endmodule

### bench/zigzag_row_interleaver_test.sv
module zigzag_row_interleaver_test;

  localparam int   SETTLE_CYCLES = zri_pkg::LINE_BYTES + 8;
  localparam int   HOLD_CYCLES = 300;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_we = 1'b0;
  logic [zri_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [zri_pkg::BYTE_W-1:0] s_tdata = '0;
  logic                       s_tuser = 1'b0;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [zri_pkg::BYTE_W-1:0] m_tdata;
  logic                       m_tlast;
  int                         pending;
  int                         fail_count;

  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int items_sent = 0;

  always #5 clk = ~clk;

  zigzag_row_interleaver u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  zigzag_row_interleaver_check u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .pending    (pending),
    .fail_count (fail_count)
  );

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(input logic kind, input logic [zri_pkg::BYTE_W-1:0] pix);
    while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait for every outstanding LED byte, then settle
  task automatic drain(input int settle);
    s_tvalid <= 1'b0;
    @(posedge clk);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_width(input logic [zri_pkg::CFG_W-1:0] w);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One image: some rows of random bytes, maybe a row cut short, then the flushes
  task automatic send_image(input int w);
    int rows;
    int cut;
    rows = $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w - 1) : w;
      for (int k = 0; k < cut; k++)
        send_item(zri_pkg::KIND_PIXEL, zri_pkg::BYTE_W'($urandom_range(0, 255)));
      if (cut < w) send_item(zri_pkg::KIND_FLUSH, zri_pkg::BYTE_W'($urandom_range(0, 255)));
    end
    for (int f = 0; f < zri_pkg::ROW_OFFSET; f++)
      send_item(zri_pkg::KIND_FLUSH, zri_pkg::BYTE_W'($urandom_range(0, 255)));
  endtask

  // Global time limit
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int w;
    int goal;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default width, partial row
    send_item(zri_pkg::KIND_PIXEL, 8'hff);
    send_item(zri_pkg::KIND_PIXEL, 8'h00);
    drain(SETTLE_CYCLES);
    // Width lowered below the column reached: next byte closes the row
    write_width(6'd1);
    send_item(zri_pkg::KIND_PIXEL, 8'haa);
    send_item(zri_pkg::KIND_FLUSH, 8'hff);
    send_item(zri_pkg::KIND_PIXEL, 8'h55);
    send_item(zri_pkg::KIND_PIXEL, 8'h00);
    for (int f = 0; f < zri_pkg::ROW_OFFSET; f++) send_item(zri_pkg::KIND_FLUSH, 8'h00);
    drain(SETTLE_CYCLES);
    // Zero width acts as one
    write_width(6'd0);
    send_item(zri_pkg::KIND_PIXEL, 8'hff);
    send_item(zri_pkg::KIND_PIXEL, 8'h81);
    for (int f = 0; f < zri_pkg::ROW_OFFSET; f++) send_item(zri_pkg::KIND_FLUSH, 8'hff);
    drain(SETTLE_CYCLES);
    // Width above the line length is clipped; flush in mid-row
    write_width(6'd63);
    send_item(zri_pkg::KIND_PIXEL, 8'h7e);
    send_item(zri_pkg::KIND_FLUSH, 8'h00);
    drain(SETTLE_CYCLES);
    write_width(6'd4);
    send_item(zri_pkg::KIND_PIXEL, 8'hff);
    send_item(zri_pkg::KIND_PIXEL, 8'h00);
    send_item(zri_pkg::KIND_PIXEL, 8'hf0);
    send_item(zri_pkg::KIND_PIXEL, 8'h0f);
    send_item(zri_pkg::KIND_FLUSH, 8'h00);
    drain(SETTLE_CYCLES);
    write_width(6'd40);
    send_item(zri_pkg::KIND_PIXEL, 8'h80);
    send_item(zri_pkg::KIND_FLUSH, 8'h01);
    drain(SETTLE_CYCLES);

    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct <= (ph == 1) ? 53 : (ph == 3) ? 33 : 0;
      stall_pct <= (ph == 2) ? 53 : (ph == 3) ? 33 : 0;
      w = $urandom_range(0, 10);
      write_width(zri_pkg::CFG_W'(w));
      if (w == 0) w = 1;
      if (w > zri_pkg::LINE_BYTES) w = zri_pkg::LINE_BYTES;
      // Long receiver hold-off while items keep coming
      if (ph == 2) hold_req <= hold_req + 1;
      goal = items_sent + 20;
      while (items_sent < goal) begin
        if ($urandom_range(0, 7) == 0)
          send_item(logic'($urandom_range(0, 1)),
                    zri_pkg::BYTE_W'($urandom_range(0, 255)));
        send_image(w);
        // Sender pause until all LED bytes are out
        if (ph == 1 && items_sent >= goal - 16 && items_sent < goal) drain(0);
      end
      drain(SETTLE_CYCLES);
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
